// ===== rtl/core/jls_pkg.sv =====
// ----------------------------------------------------------------------------
// Jacobi solver package
// Shared constants, codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package jls_pkg;

	localparam int MAX_N     = 64;
	localparam int IDX_W     = 6;
	localparam int CNT_W     = 7;
	localparam int VAL_W     = 32;
	localparam int FRAC_W    = 16;
	localparam int SWEEP_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int MAT_AW    = 2 * IDX_W;
	localparam int DIV_STEPS = 2 * FRAC_W + 1;
	localparam int DIV_CW    = 6;

	localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

	// Input operation codes.
	typedef enum logic [1:0] {
		OP_LOAD_MAT = 2'd0,
		OP_LOAD_RHS = 2'd1,
		OP_LOAD_SOL = 2'd2,
		OP_START    = 2'd3
	} op_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEPS = 2'd1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHK_RD,
		ST_CHK_TST,
		ST_ERR,
		ST_RCP_RD,
		ST_RCP_LD,
		ST_RCP_DIV,
		ST_RCP_WR,
		ST_ROW_START,
		ST_TERM_RD,
		ST_TERM_MUL,
		ST_TERM_RND,
		ST_TERM_ACC,
		ST_ROW_DIFF,
		ST_ROW_MUL,
		ST_ROW_RND,
		ST_ROW_WR,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load_en;
		logic [IDX_W-1:0] mat_row;
		logic [IDX_W-1:0] mat_col;
		logic [IDX_W-1:0] vec_idx;
		logic [IDX_W-1:0] sol_idx;
		logic             rcp_we;
		logic             nxt_we;
		logic             copy_we;
		logic             div_start;
		logic             mul_en;
		logic             mul_final;
		logic             rnd_en;
		logic             acc_clr;
		logic             acc_en;
		logic             diff_en;
		logic             out_load;
		logic             out_err;
		logic             out_last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_busy;
		logic diag_zero;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/core/jls_channels.sv =====
// ----------------------------------------------------------------------------
// Jacobi solver channels
// Valid/ready channels for request words, result words and config writes.
// ----------------------------------------------------------------------------
interface jls_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           op;
	logic [jls_pkg::IDX_W-1:0]            row;
	logic [jls_pkg::IDX_W-1:0]            col;
	logic signed [jls_pkg::VAL_W-1:0]     value;
	modport source (output valid, op, row, col, value, input ready);
	modport sink (input valid, op, row, col, value, output ready);
endinterface

interface jls_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [jls_pkg::IDX_W-1:0]            index;
	logic signed [jls_pkg::VAL_W-1:0]     result_value;
	logic                                 last;
	logic                                 status;
	modport source (output valid, index, result_value, last, status, input ready);
	modport sink (input valid, index, result_value, last, status, output ready);
endinterface

interface jls_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [jls_pkg::CFG_IDX_W-1:0]        index;
	logic [jls_pkg::CFG_DAT_W-1:0]        data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/jls_ctrl.sv =====
// ----------------------------------------------------------------------------
// Jacobi solver controller
// Holds configuration and loop counters and sequences the datapath.
// ----------------------------------------------------------------------------
module jls_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic [1:0]                     req_op,
	output logic                           req_ready,
	input  logic                           cfg_valid,
	input  logic [jls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jls_pkg::CFG_DAT_W-1:0]  cfg_data,
	output jls_pkg::cmd_t                  cmd,
	input  jls_pkg::stat_t                 stat
);

	jls_pkg::state_t state_q, state_d;
	logic [jls_pkg::CNT_W-1:0]   i_q, i_d, j_q, j_d, n_q, n_d, size_q, n_sat;
	logic [jls_pkg::SWEEP_W-1:0] s_q, s_d, sweeps_q;
	logic                        i_last;

	// Configuration registers; the user is to write them only while idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= jls_pkg::CNT_W'(1);
			sweeps_q <= jls_pkg::SWEEP_W'(1);
		end else if (cfg_valid) begin
			if (cfg_index == jls_pkg::REG_SIZE)
				size_q <= cfg_data[jls_pkg::CNT_W-1:0];
			else if (cfg_index == jls_pkg::REG_SWEEPS)
				sweeps_q <= cfg_data;
		end
	end

	// State and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jls_pkg::ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			s_q     <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			s_q     <= s_d;
			n_q     <= n_d;
		end
	end

	assign n_sat  = (size_q > jls_pkg::CNT_W'(jls_pkg::MAX_N)) ?
		jls_pkg::CNT_W'(jls_pkg::MAX_N) : size_q;
	assign i_last = (i_q + 1'b1) == n_q;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		i_d = i_q;
		j_d = j_q;
		s_d = s_q;
		n_d = n_q;
		req_ready = 1'b0;
		cmd = '0;
		cmd.mat_row = i_q[jls_pkg::IDX_W-1:0];
		cmd.mat_col = i_q[jls_pkg::IDX_W-1:0];
		cmd.vec_idx = i_q[jls_pkg::IDX_W-1:0];
		cmd.sol_idx = i_q[jls_pkg::IDX_W-1:0];
		unique case (state_q)
			jls_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load_en = req_valid && (req_op != jls_pkg::OP_START);
				if (req_valid && req_op == jls_pkg::OP_START) begin
					n_d = n_sat;
					i_d = '0;
					state_d = (n_sat == '0) ? jls_pkg::ST_ERR : jls_pkg::ST_CHK_RD;
				end
			end
			jls_pkg::ST_CHK_RD: state_d = jls_pkg::ST_CHK_TST;
			jls_pkg::ST_CHK_TST: begin
				if (stat.diag_zero) begin
					state_d = jls_pkg::ST_ERR;
				end else if (i_last) begin
					i_d = '0;
					state_d = jls_pkg::ST_RCP_RD;
				end else begin
					i_d = i_q + 1'b1;
					state_d = jls_pkg::ST_CHK_RD;
				end
			end
			jls_pkg::ST_ERR: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_err = 1'b1;
					cmd.out_last = 1'b1;
					state_d = jls_pkg::ST_IDLE;
				end
			end
			jls_pkg::ST_RCP_RD: state_d = jls_pkg::ST_RCP_LD;
			jls_pkg::ST_RCP_LD: begin
				cmd.div_start = 1'b1;
				state_d = jls_pkg::ST_RCP_DIV;
			end
			jls_pkg::ST_RCP_DIV: if (!stat.div_busy) state_d = jls_pkg::ST_RCP_WR;
			jls_pkg::ST_RCP_WR: begin
				cmd.rcp_we = 1'b1;
				if (i_last) begin
					i_d = '0;
					s_d = '0;
					state_d = (sweeps_q == '0) ? jls_pkg::ST_EMIT_RD : jls_pkg::ST_ROW_START;
				end else begin
					i_d = i_q + 1'b1;
					state_d = jls_pkg::ST_RCP_RD;
				end
			end
			jls_pkg::ST_ROW_START: begin
				cmd.acc_clr = 1'b1;
				j_d = '0;
				state_d = jls_pkg::ST_TERM_RD;
			end
			jls_pkg::ST_TERM_RD: begin
				cmd.mat_col = j_q[jls_pkg::IDX_W-1:0];
				cmd.sol_idx = j_q[jls_pkg::IDX_W-1:0];
				if (j_q == n_q) begin
					state_d = jls_pkg::ST_ROW_DIFF;
				end else if (j_q == i_q) begin
					j_d = j_q + 1'b1;
				end else begin
					state_d = jls_pkg::ST_TERM_MUL;
				end
			end
			jls_pkg::ST_TERM_MUL: begin
				cmd.mul_en = 1'b1;
				state_d = jls_pkg::ST_TERM_RND;
			end
			jls_pkg::ST_TERM_RND: begin
				cmd.rnd_en = 1'b1;
				state_d = jls_pkg::ST_TERM_ACC;
			end
			jls_pkg::ST_TERM_ACC: begin
				cmd.acc_en = 1'b1;
				j_d = j_q + 1'b1;
				state_d = jls_pkg::ST_TERM_RD;
			end
			jls_pkg::ST_ROW_DIFF: begin
				cmd.diff_en = 1'b1;
				state_d = jls_pkg::ST_ROW_MUL;
			end
			jls_pkg::ST_ROW_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_final = 1'b1;
				state_d = jls_pkg::ST_ROW_RND;
			end
			jls_pkg::ST_ROW_RND: begin
				cmd.rnd_en = 1'b1;
				state_d = jls_pkg::ST_ROW_WR;
			end
			jls_pkg::ST_ROW_WR: begin
				cmd.nxt_we = 1'b1;
				if (i_last) begin
					i_d = '0;
					state_d = jls_pkg::ST_COPY_RD;
				end else begin
					i_d = i_q + 1'b1;
					state_d = jls_pkg::ST_ROW_START;
				end
			end
			jls_pkg::ST_COPY_RD: state_d = jls_pkg::ST_COPY_WR;
			jls_pkg::ST_COPY_WR: begin
				cmd.copy_we = 1'b1;
				if (i_last) begin
					i_d = '0;
					if ((s_q + 1'b1) == sweeps_q) begin
						state_d = jls_pkg::ST_EMIT_RD;
					end else begin
						s_d = s_q + 1'b1;
						state_d = jls_pkg::ST_ROW_START;
					end
				end else begin
					i_d = i_q + 1'b1;
					state_d = jls_pkg::ST_COPY_RD;
				end
			end
			jls_pkg::ST_EMIT_RD: state_d = jls_pkg::ST_EMIT_WR;
			jls_pkg::ST_EMIT_WR: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = i_last;
					if (i_last) begin
						state_d = jls_pkg::ST_IDLE;
					end else begin
						i_d = i_q + 1'b1;
						state_d = jls_pkg::ST_EMIT_RD;
					end
				end
			end
			default: state_d = jls_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/jls_datapath.sv =====
// ----------------------------------------------------------------------------
// Jacobi solver datapath
// Stores, saturating multiply/accumulate, reciprocal divider, result register.
// ----------------------------------------------------------------------------
module jls_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [1:0]                        req_op,
	input  logic [jls_pkg::IDX_W-1:0]         req_row,
	input  logic [jls_pkg::IDX_W-1:0]         req_col,
	input  logic signed [jls_pkg::VAL_W-1:0]  req_value,
	input  jls_pkg::cmd_t                     cmd,
	output jls_pkg::stat_t                    stat,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [jls_pkg::IDX_W-1:0]         out_index,
	output logic signed [jls_pkg::VAL_W-1:0]  out_value,
	output logic                              out_last,
	output logic                              out_status
);

	localparam int VW = jls_pkg::VAL_W;

	logic signed [VW-1:0] mat_mem [jls_pkg::MAX_N*jls_pkg::MAX_N];
	logic signed [VW-1:0] rhs_mem [jls_pkg::MAX_N];
	logic signed [VW-1:0] sol_mem [jls_pkg::MAX_N];
	logic signed [VW-1:0] rcp_mem [jls_pkg::MAX_N];
	logic signed [VW-1:0] nxt_mem [jls_pkg::MAX_N];

	logic signed [VW-1:0] mat_rd_q, rhs_rd_q, sol_rd_q, rcp_rd_q, nxt_rd_q;
	logic signed [VW-1:0] mres_q, acc_q, diff_q, rcp_val;
	logic [2*VW-1:0]      prod_s1, prod_rnd;
	logic                 neg_s1;
	logic signed [VW-1:0] mul_a, mul_b;
	logic [VW-1:0]        mag_a, mag_b;
	logic signed [VW:0]   add_w, sub_w;

	logic [VW:0]                  dvd_q, quo_q, rem_step, rem_q;
	logic [VW-1:0]                dm_q, mag_d;
	logic                         dneg_q, div_busy_q, rem_ge;
	logic [jls_pkg::DIV_CW-1:0]   dcnt_q;

	logic load_mat, load_rhs, load_sol;

	assign load_mat = cmd.load_en && (req_op == jls_pkg::OP_LOAD_MAT);
	assign load_rhs = cmd.load_en && (req_op == jls_pkg::OP_LOAD_RHS);
	assign load_sol = cmd.load_en && (req_op == jls_pkg::OP_LOAD_SOL);

	// Store writes and registered reads.
	always_ff @(posedge clk) begin
		if (load_mat) mat_mem[{req_row, req_col}] <= req_value;
		if (load_rhs) rhs_mem[req_row] <= req_value;
		if (load_sol) sol_mem[req_row] <= req_value;
		else if (cmd.copy_we) sol_mem[cmd.vec_idx] <= nxt_rd_q;
		if (cmd.rcp_we) rcp_mem[cmd.vec_idx] <= rcp_val;
		if (cmd.nxt_we) nxt_mem[cmd.vec_idx] <= mres_q;
		mat_rd_q <= mat_mem[{cmd.mat_row, cmd.mat_col}];
		rhs_rd_q <= rhs_mem[cmd.vec_idx];
		rcp_rd_q <= rcp_mem[cmd.vec_idx];
		nxt_rd_q <= nxt_mem[cmd.vec_idx];
		sol_rd_q <= sol_mem[cmd.sol_idx];
	end

	// Multiplier on magnitudes, then rounding and saturation.
	assign mul_a = cmd.mul_final ? rcp_rd_q : mat_rd_q;
	assign mul_b = cmd.mul_final ? diff_q : sol_rd_q;
	assign mag_a = mul_a[VW-1] ? VW'(-mul_a) : VW'(mul_a);
	assign mag_b = mul_b[VW-1] ? VW'(-mul_b) : VW'(mul_b);
	assign prod_rnd = (prod_s1 + (2*VW)'(1 << (jls_pkg::FRAC_W-1))) >> jls_pkg::FRAC_W;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= (2*VW)'(mag_a) * (2*VW)'(mag_b);
			neg_s1  <= mul_a[VW-1] ^ mul_b[VW-1];
		end
		if (cmd.rnd_en) begin
			if (!neg_s1)
				mres_q <= (prod_rnd > (2*VW)'(jls_pkg::VMAX)) ? jls_pkg::VMAX :
					VW'(prod_rnd[VW-1:0]);
			else
				mres_q <= (prod_rnd >= (2*VW)'({1'b1, {(VW-1){1'b0}}})) ? jls_pkg::VMIN :
					VW'(-prod_rnd[VW-1:0]);
		end
	end

	// Saturating accumulate and right-hand side difference.
	assign add_w = {acc_q[VW-1], acc_q} + {mres_q[VW-1], mres_q};
	assign sub_w = {rhs_rd_q[VW-1], rhs_rd_q} - {acc_q[VW-1], acc_q};

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) acc_q <= '0;
		else if (cmd.acc_en) begin
			if (add_w[VW] != add_w[VW-1])
				acc_q <= add_w[VW] ? jls_pkg::VMIN : jls_pkg::VMAX;
			else
				acc_q <= add_w[VW-1:0];
		end
		if (cmd.diff_en) begin
			if (sub_w[VW] != sub_w[VW-1])
				diff_q <= sub_w[VW] ? jls_pkg::VMIN : jls_pkg::VMAX;
			else
				diff_q <= sub_w[VW-1:0];
		end
	end

	// Restoring divider: (2^32 + m/2) / m, one quotient bit per cycle.
	assign mag_d    = mat_rd_q[VW-1] ? VW'(-mat_rd_q) : VW'(mat_rd_q);
	assign rem_step = {rem_q[VW-1:0], dvd_q[VW]};
	assign rem_ge   = rem_step >= {1'b0, dm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			dcnt_q     <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			dcnt_q     <= jls_pkg::DIV_CW'(jls_pkg::DIV_STEPS);
		end else if (div_busy_q) begin
			dcnt_q <= dcnt_q - 1'b1;
			if (dcnt_q == jls_pkg::DIV_CW'(1)) div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dm_q   <= mag_d;
			dneg_q <= mat_rd_q[VW-1];
			dvd_q  <= {1'b1, {VW{1'b0}}} + (VW+1)'(mag_d >> 1);
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (div_busy_q) begin
			dvd_q <= {dvd_q[VW-1:0], 1'b0};
			rem_q <= rem_ge ? (rem_step - {1'b0, dm_q}) : rem_step;
			quo_q <= {quo_q[VW-1:0], rem_ge};
		end
	end

	// Signed, saturated reciprocal from the quotient magnitude.
	always_comb begin
		if (!dneg_q)
			rcp_val = (quo_q > (VW+1)'(jls_pkg::VMAX)) ? jls_pkg::VMAX : quo_q[VW-1:0];
		else
			rcp_val = (quo_q >= (VW+1)'({1'b1, {(VW-1){1'b0}}})) ? jls_pkg::VMIN :
				VW'(-quo_q[VW-1:0]);
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_index  <= cmd.vec_idx;
			out_value  <= cmd.out_err ? '0 : sol_rd_q;
			out_last   <= cmd.out_last;
			out_status <= cmd.out_err;
		end
	end

	assign stat.div_busy  = div_busy_q;
	assign stat.diag_zero = (mat_rd_q == '0);
	assign stat.out_free  = !out_valid || out_ready;

endmodule

// ===== rtl/core/jacobi_linear_solver_top.sv =====
// ----------------------------------------------------------------------------
// Jacobi linear solver, top level
// Solves A x = b by Jacobi sweeps in saturating signed Q16.16.
// ----------------------------------------------------------------------------
// Usage: req carries words op/row/col/value. Loads of A, b and x are taken
// one per cycle while the block is idle and give no result. A start word
// runs the solve for n = size_in_use (at most 64) unknowns and sweep_count
// sweeps; req stays low until the last result word has been placed in the
// output register. rsp returns x[0..n-1] with last on the final word, or a
// single error word (status 1), at index 0 if n = 0, else naming the first
// zero diagonal row. A start runs a diagonal check, then the reciprocals
// (one quotient bit per cycle in the divider), then the sweeps, each with
// its multiply-accumulates through the single multiplier and a copy pass,
// then the emit pass.
// cfg writes (index 0 size_in_use, 1 sweep_count) are always taken.
// Reset clears control state and sets n = 1, sweeps = 1; stores keep no
// reset value. When rsp stalls, the result word holds and the block waits.
// ----------------------------------------------------------------------------
module jacobi_linear_solver_top (
	input logic      clk,
	input logic      arst_n,
	jls_req_if.sink  req,
	jls_rsp_if.source rsp,
	jls_cfg_if.sink  cfg
);

	jls_pkg::cmd_t  cmd;
	jls_pkg::stat_t stat;

	assign cfg.ready = 1'b1;

	jls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.op),
		.req_ready (req.ready),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.stat      (stat)
	);

	jls_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_op     (req.op),
		.req_row    (req.row),
		.req_col    (req.col),
		.req_value  (req.value),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_index  (rsp.index),
		.out_value  (rsp.result_value),
		.out_last   (rsp.last),
		.out_status (rsp.status)
	);

endmodule
